FILE: hdl/flror_pkg.sv
// ----------------------------------------------------------------------------
// flror_pkg: shared types and constants for the fault log table
// Payload structs, command/status groups, item kinds and register indexes.
// ----------------------------------------------------------------------------
package flror_pkg;

   localparam int ENTRIES_DEF = 8;
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 2;
   localparam int SLOT_W      = 3;
   localparam int CSR_IDX_W   = 1;

   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOG   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STORE_EN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT     = 1'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] fault_code;
      logic [DATA_W-1:0] fault_extra;
      logic [DATA_W-1:0] tick_now;
      logic [SLOT_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] written_slot;
      logic              did_write;
      logic [DATA_W-1:0] entry_code;
      logic [DATA_W-1:0] entry_extra;
      logic [DATA_W-1:0] entry_boot;
      logic [DATA_W-1:0] entry_tick;
      logic [DATA_W-1:0] newest_code;
      logic [DATA_W-1:0] recorded_last;
      logic [DATA_W-1:0] abnormal_count;
   } rsp_type;

   // one table row as stored in the ram
   typedef struct packed {
      logic [DATA_W-1:0] code;
      logic [DATA_W-1:0] extra;
      logic [DATA_W-1:0] boot;
      logic [DATA_W-1:0] tick;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan_step;
      logic scan_new;
      logic rd_entry;
      logic load_entry;
      logic wr_slot;
      logic clear;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              store_en;
      logic              rd_in_range;
      logic              scan_last;
      logic              rsp_free;
   } sts_type;

endpackage

FILE: hdl/flror_ram.sv
// ----------------------------------------------------------------------------
// flror_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module flror_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/flror_ctrl.sv
// ----------------------------------------------------------------------------
// flror_ctrl: sequencing state machine
// Walks one transaction through scan, write, read and result phases.
// ----------------------------------------------------------------------------
module flror_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  flror_pkg::sts_type sts,
   output flror_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_MIN_SCAN = 4'd2;
   localparam logic [3:0] S_MIN_TAIL = 4'd3;
   localparam logic [3:0] S_WRITE    = 4'd4;
   localparam logic [3:0] S_ENT_RD   = 4'd5;
   localparam logic [3:0] S_ENT_LD   = 4'd6;
   localparam logic [3:0] S_NEW_SCAN = 4'd7;
   localparam logic [3:0] S_NEW_TAIL = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.kind)
               flror_pkg::KIND_LOG: begin
                  state_in = sts.store_en ? S_MIN_SCAN : S_NEW_SCAN;
               end
               flror_pkg::KIND_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_NEW_SCAN;
               end
               flror_pkg::KIND_READ: begin
                  state_in = sts.rd_in_range ? S_ENT_RD : S_NEW_SCAN;
               end
               default: begin
                  state_in = S_NEW_SCAN;
               end
            endcase
         end
         S_MIN_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_MIN_TAIL;
            end
         end
         S_MIN_TAIL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_slot = 1'b1;
            state_in    = S_NEW_SCAN;
         end
         S_ENT_RD: begin
            cmd.rd_entry = 1'b1;
            state_in     = S_ENT_LD;
         end
         S_ENT_LD: begin
            cmd.load_entry = 1'b1;
            state_in       = S_NEW_SCAN;
         end
         S_NEW_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_new  = 1'b1;
            if (sts.scan_last) begin
               state_in = S_NEW_TAIL;
            end
         end
         S_NEW_TAIL: begin
            cmd.scan_new = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/flror_dp.sv
// ----------------------------------------------------------------------------
// flror_dp: table datapath
// Slot ram with valid bits, scan comparator, counters and result register.
// ----------------------------------------------------------------------------
module flror_dp #(
   parameter int ENTRIES = flror_pkg::ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  flror_pkg::req_type                  req_data,
   input  logic                                csr_we,
   input  logic [flror_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [flror_pkg::DATA_W-1:0]        csr_wdata,
   input  flror_pkg::cmd_type                  cmd,
   output flror_pkg::sts_type                  sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output flror_pkg::rsp_type                  rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   // configuration
   logic                         store_en_ff;
   logic [flror_pkg::DATA_W-1:0] boot_ff;

   // latched transaction
   flror_pkg::req_type req_ff;

   // table state
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic [flror_pkg::DATA_W-1:0] last_ff, last_in;
   logic [flror_pkg::DATA_W-1:0] count_ff, count_in;

   // scan
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             cmp_idx_ff;
   logic                         cmp_pend_ff;
   logic                         rd_valid_ff;
   logic [flror_pkg::DATA_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]             at_ff, at_in;
   logic [flror_pkg::DATA_W-1:0] top_ff, top_in;
   logic [flror_pkg::DATA_W-1:0] newest_ff, newest_in;

   // per-transaction result fields
   logic [flror_pkg::SLOT_W-1:0] wslot_ff;
   logic                         dwr_ff;
   flror_pkg::slot_type          entry_ff;

   // result register
   flror_pkg::rsp_type           rsp_ff;
   logic                         rsp_valid_ff;

   // ram
   logic [IDX_W-1:0]             rd_addr;
   logic                         rd_en;
   logic [flror_pkg::SLOT_BITS-1:0] rd_raw;
   flror_pkg::slot_type          row;
   flror_pkg::slot_type          wr_row;

   assign rd_en   = cmd.scan_step | cmd.rd_entry;
   assign rd_addr = cmd.rd_entry ? IDX_W'(req_ff.entry_index) : cnt_ff;
   assign wr_row  = '{code: req_ff.fault_code, extra: req_ff.fault_extra,
                      boot: boot_ff, tick: req_ff.tick_now};

   flror_ram #(
      .WIDTH (flror_pkg::SLOT_BITS),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_slot),
      .wr_addr (at_ff),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // rows never written since clear read as zero
   assign row = rd_valid_ff ? flror_pkg::slot_type'(rd_raw) : '0;

   // status
   assign sts.kind        = req_ff.kind;
   assign sts.store_en    = store_en_ff;
   assign sts.rd_in_range = 32'(req_ff.entry_index) < 32'(ENTRIES);
   assign sts.scan_last   = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign sts.rsp_free    = ~rsp_valid_ff | rsp_ready;

   // table bookkeeping
   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         valid_in = '0;
         last_in  = '0;
         count_in = '0;
      end else if (cmd.wr_slot) begin
         valid_in[at_ff] = 1'b1;
         last_in         = req_ff.fault_code;
         count_in        = count_ff + 32'd1;
      end
   end

   // scan compare, one row per cycle
   always_comb begin
      cnt_in    = cmd.scan_step ? cnt_ff + IDX_W'(1) : '0;
      best_in   = best_ff;
      at_in     = at_ff;
      top_in    = top_ff;
      newest_in = newest_ff;
      if (cmd.capture) begin
         best_in   = flror_pkg::ALL_ONES;
         at_in     = '0;
         top_in    = '0;
         newest_in = '0;
      end else if (cmp_pend_ff) begin
         if (cmd.scan_new) begin
            if (row.code != '0 && row.boot >= top_ff) begin
               top_in    = row.boot;
               newest_in = row.code;
            end
         end else if (row.boot < best_ff) begin
            best_in = row.boot;
            at_in   = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_en_ff  <= 1'b0;
         boot_ff      <= '0;
         valid_ff     <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         cnt_ff       <= '0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               flror_pkg::CSR_STORE_EN: store_en_ff <= csr_wdata[0];
               flror_pkg::CSR_BOOT:     boot_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
         valid_ff    <= valid_in;
         last_ff     <= last_in;
         count_ff    <= count_in;
         cnt_ff      <= cnt_in;
         cmp_pend_ff <= cmd.scan_step;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= cnt_ff;
      best_ff    <= best_in;
      at_ff      <= at_in;
      top_ff     <= top_in;
      newest_ff  <= newest_in;
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.capture) begin
         req_ff   <= req_data;
         wslot_ff <= '0;
         dwr_ff   <= 1'b0;
         entry_ff <= '0;
      end else begin
         if (cmd.wr_slot) begin
            wslot_ff <= flror_pkg::SLOT_W'(at_ff);
            dwr_ff   <= 1'b1;
         end
         if (cmd.load_entry) begin
            entry_ff <= row;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.written_slot   <= wslot_ff;
         rsp_ff.did_write      <= dwr_ff;
         rsp_ff.entry_code     <= entry_ff.code;
         rsp_ff.entry_extra    <= entry_ff.extra;
         rsp_ff.entry_boot     <= entry_ff.boot;
         rsp_ff.entry_tick     <= entry_ff.tick;
         rsp_ff.newest_code    <= newest_ff;
         rsp_ff.recorded_last  <= last_ff;
         rsp_ff.abnormal_count <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a clear empties the table and the counters at once
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (valid_ff == '0 && last_ff == '0 && count_ff == '0))
      else $error("clear left table state behind");

   // the slot just written is marked valid
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_slot |=> valid_ff[$past(at_ff)])
      else $error("written slot not marked valid");

   // each logged fault bumps the count by one
   a_write_count: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_slot |=> (count_ff == $past(count_ff) + 32'd1))
      else $error("event count did not advance");

   // a result never loads over one that has not been taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overrun");

endmodule

FILE: hdl/fault_log_ring_oldest_replace_core.sv
// ----------------------------------------------------------------------------
// fault_log_ring_oldest_replace_core: fault log table, oldest-entry replace
// Logs faults into the slot with the lowest boot number, clears, reads slots.
// ----------------------------------------------------------------------------
//
//   channel   ports              direction   moves
//   req       req_valid/ready    in          one log, clear or read transaction
//   rsp       rsp_valid/ready    out         one result per transaction
//   csr       csr_we/idx/wdata   in          store enable, boot number writes
//
// sequence: one transaction at a time through a single-read-port slot ram,
//   one row compared per cycle. a log scans for the oldest slot, writes it,
//   then scans for the newest code; a read fetches its slot, then scans for
//   the newest code; a clear or ignored log only scans for the newest code
// reset: synchronous, clears config, valid bits, last code and count; the
//   table reads as zero through its valid bits with no clearing pass
// stalls: the result sits in an output register, so a new transaction is
//   taken while the previous result waits; the block holds in its final
//   step only when that register is still full
//
module fault_log_ring_oldest_replace_core #(
   parameter int ENTRIES = flror_pkg::ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request transaction
   input  logic                            req_valid,
   output logic                            req_ready,
   input  flror_pkg::req_type              req_data,
   // result transaction
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output flror_pkg::rsp_type              rsp_data,
   // configuration writes
   input  logic                            csr_we,
   input  logic [flror_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [flror_pkg::DATA_W-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   flror_pkg::cmd_type cmd;
   flror_pkg::sts_type sts;

   // sequencer: decode, scan, write, read, result hand-off
   flror_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: slot ram, valid bits, comparator, counters, result register
   flror_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
